// ----- rtl/bvm_pkg.sv -----
// shared types, widths, level and event codes for the battery voltage band monitor
package bvm_pkg;

	localparam int CODE_W    = 12;
	localparam int LEVEL_W   = 2;
	localparam int EVENT_W   = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic [CODE_W-1:0]    code_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [EVENT_W-1:0]   event_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// battery levels
	localparam level_t LVL_NORMAL = 2'd0;
	localparam level_t LVL_LOW    = 2'd1;
	localparam level_t LVL_HIGH   = 2'd2;
	localparam level_t LVL_DAMAGE = 2'd3;

	// event codes
	localparam event_t EV_DAMAGE          = 3'd0;
	localparam event_t EV_HIGH            = 3'd1;
	localparam event_t EV_LOW             = 3'd2;
	localparam event_t EV_LOW_TO_NORMAL   = 3'd3;
	localparam event_t EV_HIGH_TO_NORMAL  = 3'd4;
	localparam event_t EV_BAND_HELD       = 3'd5;
	localparam event_t EV_RELEASE_PENDING = 3'd6;

	// register indexes
	localparam cfg_idx_t REG_DAMAGE       = 3'd0;
	localparam cfg_idx_t REG_HIGH         = 3'd1;
	localparam cfg_idx_t REG_LOW          = 3'd2;
	localparam cfg_idx_t REG_LOW_RELEASE  = 3'd3;
	localparam cfg_idx_t REG_HIGH_RELEASE = 3'd4;

	// register reset values
	localparam code_t RST_DAMAGE       = 12'd4000;
	localparam code_t RST_HIGH         = 12'd3800;
	localparam code_t RST_LOW          = 12'd3000;
	localparam code_t RST_LOW_RELEASE  = 12'd3100;
	localparam code_t RST_HIGH_RELEASE = 12'd3700;

endpackage

// ----- rtl/battery_voltage_band_monitor.sv -----
// top level: sample ring, shared add/subtract unit for sum and divide, level classifier
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  in       | in_valid / in_stall   | adc_sample
//  out      | out_valid / out_stall | average_code, battery_level, event_code, in_band
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  a request is written into the ring, the filled ring entries (at most DEPTH) are
//  read and summed, then divided by the fill count one restoring step per quotient
//  bit, then classified; sum and divide share one adder, and the single ring read
//  port sets the summing time. in_stall is high from acceptance until the result is
//  loaded into the output register; a stalled result holds the sequencer in the
//  classify state, and no new request is taken while it waits. reset clears control
//  and level registers and loads the threshold reset values; the ring needs no
//  clearing since only written entries are summed.
module battery_voltage_band_monitor #(
	parameter int DEPTH       = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  bvm_pkg::code_t    adc_sample,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output bvm_pkg::code_t    average_code,
	output bvm_pkg::level_t   battery_level,
	output bvm_pkg::event_t   event_code,
	output logic              in_band,
	// configuration
	input  logic              cfg_we,
	input  bvm_pkg::cfg_idx_t cfg_index,
	input  bvm_pkg::code_t    cfg_data
);
	import bvm_pkg::*;

	// stored sample width: input bits above SAMPLE_BITS are dropped
	localparam int SW   = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SUMW = SW + CW;
	localparam int AW   = SUMW + 1;
	localparam int DCW  = $clog2(SUMW + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_CLS  = 2'd3;

	logic [1:0]     state_q;
	logic [IW-1:0]  wr_idx_q;
	logic           full_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  rd_cnt_q;
	logic           rd_vld_q;
	logic [DCW-1:0] div_cnt_q;
	logic [SUMW-1:0] acc_q;
	logic [SUMW-1:0] quo_q;
	logic [CW-1:0]  rem_q;
	logic [SW-1:0]  rd_data_q;
	level_t         level_q;

	// threshold registers
	code_t damage_q;
	code_t high_q;
	code_t low_q;
	code_t low_rel_q;
	code_t high_rel_q;

	// sample ring, one write and one registered read port
	logic [SW-1:0] ring [DEPTH];

	logic          in_acc;
	logic [SW-1:0] sample_w;
	logic [CW-1:0] next_idx;
	logic [IW-1:0] rd_addr;
	logic          rd_issue;
	logic          sum_done;
	logic          div_last;
	logic          out_free;

	// shared adder: accumulate while summing, trial subtract while dividing
	logic [AW-1:0] op_a;
	logic [AW-1:0] op_b;
	logic          op_cin;
	logic [AW:0]   add_res;
	logic [CW:0]   rem_shift;
	logic          ge;

	// classifier
	code_t  avg;
	level_t lvl_nxt;
	event_t ev_nxt;
	logic   band_nxt;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign sample_w = adc_sample[SW-1:0];
	assign next_idx = CW'(wr_idx_q) + CW'(1);
	assign rd_addr  = rd_cnt_q[IW-1:0];
	assign rd_issue = (state_q == ST_SUM) && (rd_cnt_q < count_q);
	assign sum_done = (state_q == ST_SUM) && (rd_cnt_q == count_q) && !rd_vld_q;
	assign div_last = (div_cnt_q == DCW'(SUMW - 1));
	assign out_free = !out_valid || !out_stall;

	assign rem_shift = {rem_q, quo_q[SUMW-1]};

	always_comb begin
		if (state_q == ST_DIV) begin
			op_a   = AW'(rem_shift);
			op_b   = ~AW'(count_q);
			op_cin = 1'b1;
		end else begin
			op_a   = AW'(acc_q);
			op_b   = AW'(rd_data_q);
			op_cin = 1'b0;
		end
	end

	assign add_res = {1'b0, op_a} + {1'b0, op_b} + (AW + 1)'(op_cin);
	// carry out of the subtraction means the shifted remainder covers the count
	assign ge      = add_res[AW];

	// quotient never exceeds the largest sample
	assign avg = CODE_W'(quo_q[SW-1:0]);

	// priority: damage, high, low, then in band with hysteresis release
	always_comb begin
		lvl_nxt  = level_q;
		ev_nxt   = EV_BAND_HELD;
		band_nxt = 1'b0;
		if (avg > damage_q) begin
			lvl_nxt = LVL_DAMAGE;
			ev_nxt  = EV_DAMAGE;
		end else if (avg > high_q) begin
			lvl_nxt = LVL_HIGH;
			ev_nxt  = EV_HIGH;
		end else if (avg < low_q) begin
			lvl_nxt = LVL_LOW;
			ev_nxt  = EV_LOW;
		end else begin
			band_nxt = 1'b1;
			case (level_q)
				LVL_LOW: begin
					if (avg > low_rel_q) begin
						lvl_nxt = LVL_NORMAL;
						ev_nxt  = EV_LOW_TO_NORMAL;
					end else begin
						ev_nxt = EV_RELEASE_PENDING;
					end
				end
				LVL_HIGH: begin
					if (avg < high_rel_q) begin
						lvl_nxt = LVL_NORMAL;
						ev_nxt  = EV_HIGH_TO_NORMAL;
					end else begin
						ev_nxt = EV_RELEASE_PENDING;
					end
				end
				default: begin
					// normal holds; damage has no release path
					ev_nxt = EV_BAND_HELD;
				end
			endcase
		end
	end

	// ring write and registered read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring[wr_idx_q] <= sample_w;
		end
		rd_data_q <= ring[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damage_q   <= RST_DAMAGE;
			high_q     <= RST_HIGH;
			low_q      <= RST_LOW;
			low_rel_q  <= RST_LOW_RELEASE;
			high_rel_q <= RST_HIGH_RELEASE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DAMAGE:       damage_q   <= cfg_data;
				REG_HIGH:         high_q     <= cfg_data;
				REG_LOW:          low_q      <= cfg_data;
				REG_LOW_RELEASE:  low_rel_q  <= cfg_data;
				REG_HIGH_RELEASE: high_rel_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_idx_q  <= '0;
			full_q    <= 1'b0;
			count_q   <= '0;
			rd_cnt_q  <= '0;
			rd_vld_q  <= 1'b0;
			div_cnt_q <= '0;
			level_q   <= LVL_NORMAL;
			out_valid <= 1'b0;
		end else begin
			// the classify state reloads the output register itself
			if (out_valid && !out_stall && (state_q != ST_CLS)) begin
				out_valid <= 1'b0;
			end
			rd_vld_q <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (next_idx == CW'(DEPTH)) begin
							wr_idx_q <= '0;
							full_q   <= 1'b1;
							count_q  <= CW'(DEPTH);
						end else begin
							wr_idx_q <= next_idx[IW-1:0];
							count_q  <= full_q ? CW'(DEPTH) : next_idx;
						end
						rd_cnt_q <= '0;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (sum_done) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_last) begin
						state_q <= ST_CLS;
					end
				end
				ST_CLS: begin
					if (out_free) begin
						level_q   <= lvl_nxt;
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
			end
			ST_SUM: begin
				if (rd_vld_q) begin
					acc_q <= add_res[SUMW-1:0];
				end
				if (sum_done) begin
					quo_q <= acc_q;
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				// restoring division, one quotient bit a cycle
				rem_q <= ge ? add_res[CW-1:0] : rem_shift[CW-1:0];
				quo_q <= {quo_q[SUMW-2:0], ge};
			end
			ST_CLS: begin
				if (out_free) begin
					average_code  <= avg;
					battery_level <= lvl_nxt;
					event_code    <= ev_nxt;
					in_band       <= band_nxt;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
